@@ hw/rtl/rept_pkg.sv @@
// ----------------------------------------------------------------------------
// rept_pkg: rotary encoder position tracker shared definitions
// Types, register indexes, action codes and reset values used by the tracker.
// ----------------------------------------------------------------------------
package rept_pkg;

    localparam int POS_W   = 16;
    localparam int STEP_W  = 8;
    localparam int MS_W    = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int INDEX_W = 3;
    // position plus or minus one step never leaves this width
    localparam int SUM_W   = POS_W + 2;

    localparam logic signed [POS_W-1:0] LOW_BOUND_RST  = -16'sd32767;
    localparam logic signed [POS_W-1:0] HIGH_BOUND_RST = 16'sd32766;
    localparam logic [STEP_W-1:0]       STEP_RST       = 8'd1;
    localparam logic [STEP_W-1:0]       FAST_STEP_RST  = 8'd1;
    localparam logic [MS_W-1:0]         FAST_WINDOW_RST = 16'd300;
    localparam logic [MS_W-1:0]         ARM_TIMEOUT_RST = 16'd1000;

    typedef enum logic [1:0] {
        ACT_EDGE          = 2'd0,
        ACT_LOAD_CHECKED  = 2'd1,
        ACT_LOAD_FALLBACK = 2'd2
    } action_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_LOW_BOUND   = 3'd0,
        REG_HIGH_BOUND  = 3'd1,
        REG_STEP_SIZE   = 3'd2,
        REG_FAST_STEP   = 3'd3,
        REG_WRAP_MODE   = 3'd4,
        REG_FAST_WINDOW = 3'd5,
        REG_ARM_TIMEOUT = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [POS_W-1:0] low_bound;
        logic signed [POS_W-1:0] high_bound;
        logic [STEP_W-1:0]       step_size;
        logic [STEP_W-1:0]       fast_step_size;
        logic                    wrap_mode;
        logic [MS_W-1:0]         fast_window_ms;
        logic [MS_W-1:0]         arm_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position_value;
        logic                    armed;
        logic [TIME_W-1:0]       armed_time;
        logic                    down_direction;
        logic [TIME_W-1:0]       last_step_time;
    } track_state_t;

    typedef struct packed {
        logic [1:0]              action;
        logic                    clock_level;
        logic                    data_level;
        logic [TIME_W-1:0]       now_ms;
        logic signed [POS_W-1:0] new_position;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    load_accepted;
    } result_t;

endpackage

@@ hw/rtl/rept_step.sv @@
// ----------------------------------------------------------------------------
// rept_step: tracker update logic
// Computes the next tracking state and the result word for one input word.
// ----------------------------------------------------------------------------
module rept_step
    import rept_pkg::*;
(
    input  cfg_t         cfg,
    input  track_state_t cur,
    input  item_t        item,
    output track_state_t nxt,
    output result_t      res
);

    logic [STEP_W-1:0]       fast_step;
    logic [STEP_W-1:0]       inc;
    logic [TIME_W-1:0]       since_step;
    logic [TIME_W-1:0]       since_arm;
    logic signed [SUM_W-1:0] pos_ext;
    logic signed [SUM_W-1:0] inc_ext;
    logic signed [SUM_W-1:0] lo_ext;
    logic signed [SUM_W-1:0] hi_ext;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] over_fix;
    logic signed [SUM_W-1:0] under_fix;
    logic                    load_ok;
    action_t                 act;

    always_comb
    begin
        fast_step  = (cfg.fast_step_size > cfg.step_size) ? cfg.fast_step_size : cfg.step_size;
        since_step = item.now_ms - cur.last_step_time;
        since_arm  = item.now_ms - cur.armed_time;
        inc        = (since_step < {{(TIME_W-MS_W){1'b0}}, cfg.fast_window_ms})
                     ? fast_step : cfg.step_size;

        pos_ext = SUM_W'(cur.position_value);
        inc_ext = $signed({{(SUM_W-STEP_W){1'b0}}, inc});
        lo_ext  = SUM_W'(cfg.low_bound);
        hi_ext  = SUM_W'(cfg.high_bound);
        sum     = cur.down_direction ? (pos_ext - inc_ext) : (pos_ext + inc_ext);

        // upper bound first, then lower: this order settles crossed bounds
        over_fix  = (sum > hi_ext) ? (cfg.wrap_mode ? lo_ext : hi_ext) : sum;
        under_fix = (over_fix < lo_ext) ? (cfg.wrap_mode ? hi_ext : lo_ext) : over_fix;

        load_ok = (item.new_position >= cfg.low_bound) && (item.new_position <= cfg.high_bound);
        act     = action_t'(item.action);

        nxt               = cur;
        res.load_accepted = 1'b0;

        unique case (act)
            ACT_EDGE:
            begin
                if (!item.clock_level)
                begin
                    if (!cur.armed || (since_arm > {{(TIME_W-MS_W){1'b0}}, cfg.arm_timeout_ms}))
                    begin
                        nxt.armed          = 1'b1;
                        nxt.armed_time     = item.now_ms;
                        nxt.down_direction = item.data_level;
                    end
                end
                else if (cur.armed)
                begin
                    nxt.last_step_time = item.now_ms;
                    nxt.position_value = under_fix[POS_W-1:0];
                    nxt.armed          = 1'b0;
                end
            end
            ACT_LOAD_CHECKED:
            begin
                if (load_ok)
                begin
                    nxt.position_value = item.new_position;
                    res.load_accepted  = 1'b1;
                end
            end
            ACT_LOAD_FALLBACK:
            begin
                nxt.position_value = load_ok ? item.new_position : cfg.low_bound;
                res.load_accepted  = load_ok;
            end
            default:
            begin
                // unused action code: report position only
            end
        endcase

        res.position = nxt.position_value;
    end

endmodule

@@ hw/rtl/rotary_encoder_position_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// rotary_encoder_position_tracker_unit: bounded encoder position tracker
// Steps a bounded position on encoder clock-line events, with a fast step for
// quick turns, and takes checked and fallback position loads.
// ----------------------------------------------------------------------------
// Path: an accepted word passes the input word register, then the result
//   register; the tracking state updates with the result.
// Throughput: one word per cycle while out_ready is high; a stalled result holds the input.
// Reset: configuration returns to its defaults, position to the low bound
//   default, the detent disarmed, both time stamps zero, both stages empty.
module rotary_encoder_position_tracker_unit
    import rept_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [INDEX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               action,
    input  logic                     clock_level,
    input  logic                     data_level,
    input  logic [TIME_W-1:0]        now_ms,
    input  logic signed [POS_W-1:0]  new_position,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [POS_W-1:0]  position,
    output logic                     load_accepted
);

    cfg_t         cfg_reg;
    track_state_t state_reg;
    track_state_t state_next;
    item_t        item_reg;
    logic         item_valid_reg;
    result_t      res_reg;
    result_t      res_next;
    logic         out_valid_reg;
    logic         advance;
    reg_index_t   widx;

    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign widx     = reg_index_t'(cfg_index);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_bound      <= LOW_BOUND_RST;
            cfg_reg.high_bound     <= HIGH_BOUND_RST;
            cfg_reg.step_size      <= STEP_RST;
            cfg_reg.fast_step_size <= FAST_STEP_RST;
            cfg_reg.wrap_mode      <= 1'b0;
            cfg_reg.fast_window_ms <= FAST_WINDOW_RST;
            cfg_reg.arm_timeout_ms <= ARM_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (widx)
                REG_LOW_BOUND:   cfg_reg.low_bound      <= $signed(cfg_data[POS_W-1:0]);
                REG_HIGH_BOUND:  cfg_reg.high_bound     <= $signed(cfg_data[POS_W-1:0]);
                REG_STEP_SIZE:   cfg_reg.step_size      <= cfg_data[STEP_W-1:0];
                REG_FAST_STEP:   cfg_reg.fast_step_size <= cfg_data[STEP_W-1:0];
                REG_WRAP_MODE:   cfg_reg.wrap_mode      <= cfg_data[0];
                REG_FAST_WINDOW: cfg_reg.fast_window_ms <= cfg_data[MS_W-1:0];
                REG_ARM_TIMEOUT: cfg_reg.arm_timeout_ms <= cfg_data[MS_W-1:0];
                default:
                begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.action       <= action;
            item_reg.clock_level  <= clock_level;
            item_reg.data_level   <= data_level;
            item_reg.now_ms       <= now_ms;
            item_reg.new_position <= new_position;
        end
    end

    rept_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // tracking state advances together with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.position_value <= LOW_BOUND_RST;
            state_reg.armed          <= 1'b0;
            state_reg.armed_time     <= '0;
            state_reg.down_direction <= 1'b0;
            state_reg.last_step_time <= '0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign position      = res_reg.position;
    assign load_accepted = res_reg.load_accepted;

    // an accepted load always lands inside the bounds
    a_load_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.load_accepted) |->
        (res_reg.position >= cfg_reg.low_bound && res_reg.position <= cfg_reg.high_bound))
        else $error("accepted load outside bounds");

    // a clock-low edge event always leaves the detent armed
    a_low_edge_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.action == ACT_EDGE && !item_reg.clock_level) |=> state_reg.armed)
        else $error("clock-low event left detent disarmed");

    // state holds while no word advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("tracking state changed without an advancing word");

    // reported position matches the stored position
    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.position == state_reg.position_value))
        else $error("result position differs from state");

    // an empty input stage always takes a word
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> in_ready)
        else $error("input stalled while empty");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: rotary encoder position tracker testbench
// Drives encoder clock-edge events and position loads through the valid/ready
// input, tracks the expected position and load flag in a local copy of the
// tracker, and checks every result word in order under several register
// settings, with random idling on both sides and forced back-pressure.
// ----------------------------------------------------------------------------
module tb;
    import rept_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 3000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [INDEX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              action = ACT_EDGE;
    logic                    clock_level = 1'b0;
    logic                    data_level = 1'b0;
    logic [TIME_W-1:0]       now_ms = '0;
    logic signed [POS_W-1:0] new_position = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [POS_W-1:0] position;
    logic                    load_accepted;

    rotary_encoder_position_tracker_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .clock_level  (clock_level),
        .data_level   (data_level),
        .now_ms       (now_ms),
        .new_position (new_position),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .position     (position),
        .load_accepted(load_accepted)
    );

    always #5 clk = ~clk;

    // register copy
    logic signed [POS_W-1:0] lim_lo      = LOW_BOUND_RST;
    logic signed [POS_W-1:0] lim_hi      = HIGH_BOUND_RST;
    logic [STEP_W-1:0]       slow_step   = STEP_RST;
    logic [STEP_W-1:0]       quick_step  = FAST_STEP_RST;
    logic                    wrap_on     = 1'b0;
    logic [MS_W-1:0]         quick_win   = FAST_WINDOW_RST;
    logic [MS_W-1:0]         rearm_after = ARM_TIMEOUT_RST;

    // tracker copy
    logic signed [POS_W-1:0] trk_pos       = LOW_BOUND_RST;
    logic                    trk_armed     = 1'b0;
    logic [TIME_W-1:0]       trk_armed_at  = '0;
    logic                    trk_down      = 1'b0;
    logic [TIME_W-1:0]       trk_last_step = '0;

    item_t   pending_words[$];
    result_t expected_positions[$];

    bit          idle_on = 1'b1;
    int          hold_stamp = 0;
    int          hold_seen;
    int          hold_left;
    int          send_gap;
    int          recv_wait;
    int          fault_count = 0;
    int          words_in = 0;
    int          results_checked = 0;
    int          settings_used = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_ms = '0;

    function automatic result_t track_word(input item_t w);
        result_t     r;
        logic [31:0] since;
        logic [7:0]  quick_inc;
        logic [7:0]  inc;
        int          moved;
        r.load_accepted = 1'b0;
        case (w.action)
            ACT_EDGE: begin
                if (!w.clock_level) begin
                    since = w.now_ms - trk_armed_at;
                    if (!trk_armed || since > {16'd0, rearm_after}) begin
                        trk_armed    = 1'b1;
                        trk_armed_at = w.now_ms;
                        trk_down     = w.data_level;
                    end
                end else if (trk_armed) begin
                    quick_inc = (quick_step > slow_step) ? quick_step : slow_step;
                    since = w.now_ms - trk_last_step;
                    inc = (since < {16'd0, quick_win}) ? quick_inc : slow_step;
                    trk_last_step = w.now_ms;
                    moved = trk_down ? int'(trk_pos) - int'(inc) : int'(trk_pos) + int'(inc);
                    // upper bound first, then lower: matters when the bounds cross
                    if (moved > int'(lim_hi))
                        moved = wrap_on ? int'(lim_lo) : int'(lim_hi);
                    if (moved < int'(lim_lo))
                        moved = wrap_on ? int'(lim_hi) : int'(lim_lo);
                    trk_pos   = moved[15:0];
                    trk_armed = 1'b0;
                end
            end
            ACT_LOAD_CHECKED, ACT_LOAD_FALLBACK: begin
                if ($signed(w.new_position) >= lim_lo && $signed(w.new_position) <= lim_hi)
                begin
                    trk_pos = w.new_position;
                    r.load_accepted = 1'b1;
                end else if (w.action == ACT_LOAD_FALLBACK) begin
                    trk_pos = lim_lo;
                end
            end
            default: ;
        endcase
        r.position = trk_pos;
        return r;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n) begin : drive_words
        item_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || in_ready) begin
            if (send_gap != 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_words.size() != 0) begin
                nxt = pending_words.pop_front();
                in_valid     <= 1'b1;
                action       <= nxt.action;
                clock_level  <= nxt.clock_level;
                data_level   <= nxt.data_level;
                now_ms       <= nxt.now_ms;
                new_position <= nxt.new_position;
                send_gap     <= idle_on ? $urandom_range(0, 9) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n) begin : take_results
        int stall;
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_stamp) begin
            hold_seen <= hold_stamp;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (out_ready) begin
            if (out_valid) begin
                stall = idle_on ? $urandom_range(0, 9) : 0;
                if (stall != 0) begin
                    out_ready <= 1'b0;
                    recv_wait <= stall - 1;
                end
            end
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // check results, then predict from the word taken at this edge
    always @(posedge clk) begin : watch_ports
        item_t   seen;
        result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_positions.size() == 0) begin
                    $error("result with no word pending: position %0d", position);
                    fault_count++;
                end else begin
                    want = expected_positions.pop_front();
                    results_checked++;
                    if (position !== $signed(want.position)) begin
                        $error("position: expected %0d, got %0d", $signed(want.position),
                               position);
                        fault_count++;
                    end
                    if (load_accepted !== want.load_accepted) begin
                        $error("load_accepted: expected %0d, got %0d", want.load_accepted,
                               load_accepted);
                        fault_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                seen.action       = action;
                seen.clock_level  = clock_level;
                seen.data_level   = data_level;
                seen.now_ms       = now_ms;
                seen.new_position = new_position;
                expected_positions.push_back(track_word(seen));
                words_in++;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d words in, %0d results pending", words_in,
                     expected_positions.size());
            $display("rotary_encoder_position_tracker_unit verification failed");
            $finish;
        end
    end

    task automatic queue_word(input logic [1:0] act, input logic clk_lvl,
                              input logic dat_lvl, input logic [31:0] stamp,
                              input logic [15:0] pos);
        item_t w;
        w.action       = act;
        w.clock_level  = clk_lvl;
        w.data_level   = dat_lvl;
        w.now_ms       = stamp;
        w.new_position = pos;
        pending_words.push_back(w);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_LOW_BOUND:   lim_lo      = val;
            REG_HIGH_BOUND:  lim_hi      = val;
            REG_STEP_SIZE:   slow_step   = val[7:0];
            REG_FAST_STEP:   quick_step  = val[7:0];
            REG_WRAP_MODE:   wrap_on     = val[0];
            REG_FAST_WINDOW: quick_win   = val;
            REG_ARM_TIMEOUT: rearm_after = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int lo, input int hi, input int st, input int fs,
                                 input int wr, input int win, input int tmo);
        write_reg(REG_LOW_BOUND, lo[15:0]);
        write_reg(REG_HIGH_BOUND, hi[15:0]);
        write_reg(REG_STEP_SIZE, st[15:0]);
        write_reg(REG_FAST_STEP, fs[15:0]);
        write_reg(REG_WRAP_MODE, wr[15:0]);
        write_reg(REG_FAST_WINDOW, win[15:0]);
        write_reg(REG_ARM_TIMEOUT, tmo[15:0]);
        settings_used++;
    endtask

    // wait until every word has gone through, then let the pipe settle
    task automatic drain_pipeline();
        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_positions.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic bump_time();
        case ($urandom_range(0, 3))
            0:       clock_ms += $urandom_range(0, 400);
            1:       clock_ms += $urandom_range(0, 3000);
            2:       clock_ms += $urandom_range(0, 140000);
            default: clock_ms = $urandom();
        endcase
    endtask

    function automatic logic [15:0] pick_position();
        int span;
        span = int'(lim_hi) - int'(lim_lo);
        if (span < 0)
            span = 0;
        case ($urandom_range(0, 3))
            0:       return 16'($urandom());
            1:       return 16'(int'(lim_lo) + int'($urandom_range(0, 2)) - 1);
            2:       return 16'(int'(lim_hi) + int'($urandom_range(0, 2)) - 1);
            default: return 16'(int'(lim_lo) + int'($urandom_range(0, span)));
        endcase
    endfunction

    // mostly clean detents (arm, maybe a bounce, step), then loads, then noise
    task automatic gen_random(input int n);
        int made;
        int pick;
        made = 0;
        @(negedge clk);
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                bump_time();
                queue_word(ACT_EDGE, 1'b0, 1'($urandom_range(0, 1)), clock_ms,
                           16'($urandom()));
                if ($urandom_range(0, 3) == 0) begin
                    bump_time();
                    queue_word(ACT_EDGE, 1'b0, 1'($urandom_range(0, 1)), clock_ms,
                               16'($urandom()));
                    made++;
                end
                bump_time();
                queue_word(ACT_EDGE, 1'b1, 1'($urandom_range(0, 1)), clock_ms,
                           16'($urandom()));
                made += 2;
            end else if (pick < 90) begin
                queue_word((pick < 78) ? ACT_LOAD_CHECKED : ACT_LOAD_FALLBACK,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
                           pick_position());
                made++;
            end else begin
                queue_word((pick < 95) ? ACT_RESERVED : ACT_EDGE, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), $urandom(), 16'($urandom()));
                made++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset settings: clamping, timeout re-arm, time wrap
        @(negedge clk);
        queue_word(ACT_RESERVED, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        queue_word(ACT_EDGE, 1'b1, 1'b0, 32'd50, 16'h0000);
        queue_word(ACT_LOAD_CHECKED, 1'b0, 1'b0, 32'd60, 16'sd32767);
        queue_word(ACT_LOAD_CHECKED, 1'b0, 1'b0, 32'd70, -16'sd32768);
        queue_word(ACT_LOAD_FALLBACK, 1'b0, 1'b0, 32'd80, -16'sd32768);
        queue_word(ACT_LOAD_CHECKED, 1'b0, 1'b0, 32'd90, 16'sd32766);
        queue_word(ACT_EDGE, 1'b0, 1'b0, 32'd2000, 16'h0000);
        queue_word(ACT_EDGE, 1'b0, 1'b1, 32'd2500, 16'h0000);
        queue_word(ACT_EDGE, 1'b1, 1'b0, 32'd2600, 16'h0000);
        queue_word(ACT_EDGE, 1'b0, 1'b1, 32'hFFFF_FF00, 16'h0000);
        queue_word(ACT_EDGE, 1'b0, 1'b0, 32'h0000_0400, 16'h0000);
        queue_word(ACT_EDGE, 1'b1, 1'b1, 32'h0000_0500, 16'h0000);
        queue_word(ACT_LOAD_CHECKED, 1'b1, 1'b1, 32'h0000_0501, -16'sd32767);
        queue_word(ACT_EDGE, 1'b0, 1'b1, 32'h0000_0510, 16'h0000);
        queue_word(ACT_EDGE, 1'b1, 1'b0, 32'h0000_0520, 16'h0000);
        drain_pipeline();

        // narrow window with wrap, fast step above the slow one
        apply_setting(-100, 100, 3, 10, 1, 500, 200);
        @(negedge clk);
        clock_ms = 32'h0000_1000;
        queue_word(ACT_LOAD_FALLBACK, 1'b0, 1'b0, clock_ms, 16'sd99);
        queue_word(ACT_EDGE, 1'b0, 1'b0, clock_ms + 10, 16'h0000);
        queue_word(ACT_EDGE, 1'b1, 1'b0, clock_ms + 20, 16'h0000);
        queue_word(ACT_LOAD_CHECKED, 1'b0, 1'b0, clock_ms + 30, -16'sd99);
        queue_word(ACT_EDGE, 1'b0, 1'b1, clock_ms + 40, 16'h0000);
        queue_word(ACT_EDGE, 1'b1, 1'b1, clock_ms + 45, 16'h0000);
        drain_pipeline();

        // stall the output while words keep coming, so the input backs up
        idle_on = 1'b0;
        hold_stamp++;
        gen_random(150);
        drain_pipeline();
        idle_on = 1'b1;
        gen_random(100);
        drain_pipeline();

        apply_setting(-32768, 32767, 255, 255, 0, 65535, 65535);
        gen_random(200);
        drain_pipeline();

        // crossed bounds
        apply_setting(10, -10, 1, 0, 1, 0, 0);
        gen_random(200);
        drain_pipeline();

        apply_setting(0, 0, 0, 0, 0, 1000, 1000);
        idle_on = 1'b0;
        gen_random(100);
        drain_pipeline();
        idle_on = 1'b1;
        gen_random(100);
        drain_pipeline();

        // fast step below the slow one
        apply_setting(-20, 20, 7, 2, 0, 300, 50);
        gen_random(200);
        drain_pipeline();

        apply_setting(-32768, 32767, 200, 255, 1, 65535, 0);
        gen_random(200);
        drain_pipeline();

        repeat (8) @(posedge clk);
        if (expected_positions.size() != 0) begin
            $error("%0d results never arrived", expected_positions.size());
            fault_count++;
        end
        $display("run covered %0d words and %0d checked results over %0d register settings",
                 words_in, results_checked, settings_used);
        $display("mismatches: %0d", fault_count);
        if (fault_count == 0)
            $display("rotary_encoder_position_tracker_unit verification clean");
        else
            $display("rotary_encoder_position_tracker_unit verification failed");
        $finish;
    end

endmodule
